// ===== sv/dbbc_pkg.sv =====
// package: shared constants and register codes for the debounced bpm counter
`timescale 1ns / 1ps

package dbbc_pkg;

  // widths of the channels
  localparam int TS_W       = 32;
  localparam int COUNT_W    = 10;
  localparam int BPM_W      = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int DEB_W      = 16;
  localparam int BASE_W     = 8;
  localparam int STEP_W     = 6;
  localparam int MAX_W      = 10;

  // product of step and count, and sums built on it
  localparam int PROD_W = STEP_W + COUNT_W;
  localparam int SUM_W  = PROD_W + 1;

  // button order, also the order in which handlers run
  localparam int NUM_BUTTONS = 3;
  localparam int BTN_UP      = 0;
  localparam int BTN_DOWN    = 1;
  localparam int BTN_TOGGLE  = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOCK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_LOCK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_BASE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_STEP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BPM_MAX     = 3'd5;

  // register reset values
  localparam logic [DEB_W-1:0]  DEBOUNCE_RST    = 16'd20;
  localparam logic [DEB_W-1:0]  PRESS_LOCK_RST  = 16'd150;
  localparam logic [DEB_W-1:0]  TOGGLE_LOCK_RST = 16'd400;
  localparam logic [BASE_W-1:0] BPM_BASE_RST    = 8'd60;
  localparam logic [STEP_W-1:0] BPM_STEP_RST    = 6'd10;
  localparam logic [MAX_W-1:0]  BPM_MAX_RST     = 10'd250;

  // saturation limits
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [BPM_W-1:0]   BPM_OUT_MAX = '1;

endpackage

// ===== sv/dbbc_if.sv =====
// interfaces: poll channel, result channel and configuration write channel
`timescale 1ns / 1ps

interface dbbc_poll_if;
  logic                      valid;
  logic                      ready;
  logic [dbbc_pkg::TS_W-1:0] now_ms;
  logic                      up_level;
  logic                      down_level;
  logic                      toggle_level;

  modport source (output valid, now_ms, up_level, down_level, toggle_level, input ready);
  modport sink   (input valid, now_ms, up_level, down_level, toggle_level, output ready);
endinterface

interface dbbc_result_if;
  logic                         valid;
  logic                         ready;
  logic [dbbc_pkg::BPM_W-1:0]   bpm_value;
  logic [dbbc_pkg::COUNT_W-1:0] touches;
  logic                         link_online;

  modport source (output valid, bpm_value, touches, link_online, input ready);
  modport sink   (input valid, bpm_value, touches, link_online, output ready);
endinterface

interface dbbc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dbbc_pkg::CFG_IDX_W-1:0]  index;
  logic [dbbc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/dbbc_debounce.sv =====
// one button: debounce state and the press event on a new stable low level
`timescale 1ns / 1ps

module dbbc_debounce (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic                        level,
  input  logic [dbbc_pkg::TS_W-1:0]   now_ms,
  input  logic [dbbc_pkg::DEB_W-1:0]  debounce_ms,
  output logic                        press
);

  logic                      stable_level;
  logic                      last_level;
  logic [dbbc_pkg::TS_W-1:0] change_time;

  logic                      level_changed;
  logic [dbbc_pkg::TS_W-1:0] change_time_next;
  logic [dbbc_pkg::TS_W-1:0] held_time;
  logic                      settle;

  // change timer restarts on any new level, then the held time is checked
  always_comb begin
    level_changed    = (level != last_level);
    change_time_next = level_changed ? now_ms : change_time;
    held_time        = now_ms - change_time_next;
    settle           = (held_time > {{(dbbc_pkg::TS_W - dbbc_pkg::DEB_W){1'b0}}, debounce_ms})
                       && (level != stable_level);
    press            = settle && !level;
  end

  // state moves only when a word is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= 1'b1;
      last_level   <= 1'b1;
      change_time  <= '0;
    end else if (advance) begin
      last_level  <= level;
      change_time <= change_time_next;
      if (settle) begin
        stable_level <= level;
      end
    end
  end

endmodule

// ===== sv/debounced_button_bpm_counter_core.sv =====
// top level: poll register, button handlers, touch counter and result register
`timescale 1ns / 1ps

// Takes one poll word per clock. A word accepted on the poll channel is held in
// the poll register; the debounce, lockout and counter logic runs on it there
// and its result word is loaded into the result register when that register is
// free, so the sustained rate is one word per cycle while the result side keeps
// ready high. Stalls on the result side back up through the poll register.
// Configuration writes are always taken (ready tied high) and must only be
// issued while no poll is in flight; indexes beyond the six registers are
// ignored.
module debounced_button_bpm_counter_core (
  input  logic clk,
  input  logic rst,
  dbbc_poll_if.sink     poll,
  dbbc_result_if.source result,
  dbbc_cfg_if.sink      cfg
);

  // configuration registers
  logic [dbbc_pkg::DEB_W-1:0]  debounce_ms;
  logic [dbbc_pkg::DEB_W-1:0]  press_lockout_ms;
  logic [dbbc_pkg::DEB_W-1:0]  toggle_lockout_ms;
  logic [dbbc_pkg::BASE_W-1:0] bpm_base;
  logic [dbbc_pkg::STEP_W-1:0] bpm_step;
  logic [dbbc_pkg::MAX_W-1:0]  bpm_max;

  // poll register
  logic                      poll_valid;
  logic [dbbc_pkg::TS_W-1:0] poll_now;
  logic [dbbc_pkg::NUM_BUTTONS-1:0] poll_level;

  // result register
  logic                         res_valid;
  logic [dbbc_pkg::BPM_W-1:0]   res_bpm;
  logic [dbbc_pkg::COUNT_W-1:0] res_touches;
  logic                         res_online;

  // handler state
  logic [dbbc_pkg::TS_W-1:0]    accept_time [dbbc_pkg::NUM_BUTTONS];
  logic [dbbc_pkg::COUNT_W-1:0] touch_count;
  logic                         online_flag;

  logic                             res_free;
  logic                             advance;
  logic [dbbc_pkg::NUM_BUTTONS-1:0] press;
  logic [dbbc_pkg::NUM_BUTTONS-1:0] lock_pass;
  logic [dbbc_pkg::NUM_BUTTONS-1:0] take;
  logic [dbbc_pkg::PROD_W-1:0]      prod;
  logic [dbbc_pkg::SUM_W-1:0]       up_bpm;
  logic [dbbc_pkg::SUM_W-1:0]       prod_next;
  logic [dbbc_pkg::SUM_W-1:0]       bpm_full;
  logic                             up_inc;
  logic                             down_dec;
  logic [dbbc_pkg::COUNT_W-1:0]     count_up;
  logic [dbbc_pkg::COUNT_W-1:0]     touch_count_next;
  logic                             online_flag_next;
  logic [dbbc_pkg::BPM_W-1:0]       bpm_next;

  // handshake: result register empties or drains, poll register follows
  assign res_free     = !res_valid || result.ready;
  assign advance      = poll_valid && res_free;
  assign poll.ready   = !poll_valid || res_free;
  assign cfg.ready    = 1'b1;
  assign result.valid       = res_valid;
  assign result.bpm_value   = res_bpm;
  assign result.touches     = res_touches;
  assign result.link_online = res_online;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ms       <= dbbc_pkg::DEBOUNCE_RST;
      press_lockout_ms  <= dbbc_pkg::PRESS_LOCK_RST;
      toggle_lockout_ms <= dbbc_pkg::TOGGLE_LOCK_RST;
      bpm_base          <= dbbc_pkg::BPM_BASE_RST;
      bpm_step          <= dbbc_pkg::BPM_STEP_RST;
      bpm_max           <= dbbc_pkg::BPM_MAX_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        dbbc_pkg::REG_DEBOUNCE:    debounce_ms       <= cfg.data;
        dbbc_pkg::REG_PRESS_LOCK:  press_lockout_ms  <= cfg.data;
        dbbc_pkg::REG_TOGGLE_LOCK: toggle_lockout_ms <= cfg.data;
        dbbc_pkg::REG_BPM_BASE:    bpm_base          <= cfg.data[dbbc_pkg::BASE_W-1:0];
        dbbc_pkg::REG_BPM_STEP:    bpm_step          <= cfg.data[dbbc_pkg::STEP_W-1:0];
        dbbc_pkg::REG_BPM_MAX:     bpm_max           <= cfg.data[dbbc_pkg::MAX_W-1:0];
        default: ;
      endcase
    end
  end

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (poll.ready) begin
      poll_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.valid && poll.ready) begin
      poll_now   <= poll.now_ms;
      poll_level <= {poll.toggle_level, poll.down_level, poll.up_level};
    end
  end

  // per-button debounce
  for (genvar b = 0; b < dbbc_pkg::NUM_BUTTONS; b++) begin : g_btn
    dbbc_debounce u_deb (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .level       (poll_level[b]),
      .now_ms      (poll_now),
      .debounce_ms (debounce_ms),
      .press       (press[b])
    );
  end

  // lockout windows, wrapping time since last accepted press
  always_comb begin
    lock_pass[dbbc_pkg::BTN_UP] = (poll_now - accept_time[dbbc_pkg::BTN_UP]) >=
      {{(dbbc_pkg::TS_W - dbbc_pkg::DEB_W){1'b0}}, press_lockout_ms};
    lock_pass[dbbc_pkg::BTN_DOWN] = (poll_now - accept_time[dbbc_pkg::BTN_DOWN]) >=
      {{(dbbc_pkg::TS_W - dbbc_pkg::DEB_W){1'b0}}, press_lockout_ms};
    lock_pass[dbbc_pkg::BTN_TOGGLE] = (poll_now - accept_time[dbbc_pkg::BTN_TOGGLE]) >=
      {{(dbbc_pkg::TS_W - dbbc_pkg::DEB_W){1'b0}}, toggle_lockout_ms};
    take = press & lock_pass;
  end

  // handlers in order up, down, toggle; bpm tracked as step*count plus deltas
  always_comb begin
    prod   = dbbc_pkg::PROD_W'(bpm_step) * dbbc_pkg::PROD_W'(touch_count);
    up_bpm = dbbc_pkg::SUM_W'(bpm_base) + dbbc_pkg::SUM_W'(prod)
             + dbbc_pkg::SUM_W'(bpm_step);
    up_inc = take[dbbc_pkg::BTN_UP]
             && (up_bpm <= dbbc_pkg::SUM_W'(bpm_max))
             && (touch_count != dbbc_pkg::COUNT_MAX);
    count_up = up_inc ? touch_count + 1'b1 : touch_count;
    down_dec = take[dbbc_pkg::BTN_DOWN] && (count_up != '0);
    touch_count_next = down_dec ? count_up - 1'b1 : count_up;
    online_flag_next = online_flag ^ take[dbbc_pkg::BTN_TOGGLE];

    prod_next = dbbc_pkg::SUM_W'(prod);
    if (up_inc && !down_dec) begin
      prod_next = dbbc_pkg::SUM_W'(prod) + dbbc_pkg::SUM_W'(bpm_step);
    end else if (down_dec && !up_inc) begin
      prod_next = dbbc_pkg::SUM_W'(prod) - dbbc_pkg::SUM_W'(bpm_step);
    end
    bpm_full = prod_next + dbbc_pkg::SUM_W'(bpm_base);
    bpm_next = (bpm_full > dbbc_pkg::SUM_W'(dbbc_pkg::BPM_OUT_MAX))
               ? dbbc_pkg::BPM_OUT_MAX : bpm_full[dbbc_pkg::BPM_W-1:0];
  end

  // handler state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dbbc_pkg::NUM_BUTTONS; i++) begin
        accept_time[i] <= '0;
      end
      touch_count <= '0;
      online_flag <= 1'b1;
    end else if (advance) begin
      for (int i = 0; i < dbbc_pkg::NUM_BUTTONS; i++) begin
        if (take[i]) begin
          accept_time[i] <= poll_now;
        end
      end
      touch_count <= touch_count_next;
      online_flag <= online_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= poll_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_bpm     <= bpm_next;
      res_touches <= touch_count_next;
      res_online  <= online_flag_next;
    end
  end

  // count moves by at most one per word
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    advance |=> (touch_count == $past(touch_count)
                 || touch_count == $past(touch_count) + 1'b1
                 || touch_count + 1'b1 == $past(touch_count)))
    else $error("touch count jumped by more than one");

  // state only changes when a word is processed
  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(touch_count) && $stable(online_flag)))
    else $error("handler state changed without a poll word");

  // a processed word always lands in the result register
  a_result_load: assert property (@(posedge clk) disable iff (rst)
    advance |=> (res_valid && res_touches == touch_count && res_online == online_flag))
    else $error("result word does not match handler state");

endmodule

// ===== sim/tb.sv =====
// testbench for the debounced button bpm counter core, self-checking with its own predictor
`timescale 1ns / 1ps

module tb;

  localparam int IDLE_LIMIT = 2000;
  // indexes past the last register, the block must ignore them
  localparam logic [dbbc_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [dbbc_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [dbbc_pkg::TS_W-1:0] now_ms;
    logic                      up_level;
    logic                      down_level;
    logic                      toggle_level;
  } poll_word_t;

  typedef struct packed {
    logic [dbbc_pkg::BPM_W-1:0]   bpm_value;
    logic [dbbc_pkg::COUNT_W-1:0] touches;
    logic                         link_online;
  } bpm_reading_t;

  logic clk;
  logic rst;

  dbbc_poll_if   poll();
  dbbc_result_if result();
  dbbc_cfg_if    cfg();

  debounced_button_bpm_counter_core u_top (
    .clk    (clk),
    .rst    (rst),
    .poll   (poll),
    .result (result),
    .cfg    (cfg)
  );

  // clock, 20 ns period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  poll_word_t   poll_backlog[$];
  bpm_reading_t readings_due[$];
  int           fails;
  int           tx_wait, tx_calm, rx_wait, rx_calm;
  int           idle_cycles;

  // predictor copy of the registers and button state
  logic [dbbc_pkg::DEB_W-1:0]   cf_debounce, cf_press_lock, cf_toggle_lock;
  logic [dbbc_pkg::BASE_W-1:0]  cf_base;
  logic [dbbc_pkg::STEP_W-1:0]  cf_step;
  logic [dbbc_pkg::MAX_W-1:0]   cf_max;
  logic                         btn_stable[dbbc_pkg::NUM_BUTTONS];
  logic                         btn_seen[dbbc_pkg::NUM_BUTTONS];
  logic [dbbc_pkg::TS_W-1:0]    btn_changed_at[dbbc_pkg::NUM_BUTTONS];
  logic [dbbc_pkg::TS_W-1:0]    btn_taken_at[dbbc_pkg::NUM_BUTTONS];
  logic [dbbc_pkg::COUNT_W-1:0] touch_tally;
  logic                         online_now;

  // stimulus timeline and per-button hold pattern
  logic [dbbc_pkg::TS_W-1:0] clock_ms;
  logic                      press_hold[dbbc_pkg::NUM_BUTTONS];
  int                        hold_left[dbbc_pkg::NUM_BUTTONS];

  // wait drawn per word: mostly 0..13, with runs of back-to-back words
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 13);
  endfunction

  function automatic void wipe_counter_state();
    cf_debounce    = dbbc_pkg::DEBOUNCE_RST;
    cf_press_lock  = dbbc_pkg::PRESS_LOCK_RST;
    cf_toggle_lock = dbbc_pkg::TOGGLE_LOCK_RST;
    cf_base        = dbbc_pkg::BPM_BASE_RST;
    cf_step        = dbbc_pkg::BPM_STEP_RST;
    cf_max         = dbbc_pkg::BPM_MAX_RST;
    for (int b = 0; b < dbbc_pkg::NUM_BUTTONS; b++) begin
      btn_stable[b]     = 1'b1;
      btn_seen[b]       = 1'b1;
      btn_changed_at[b] = '0;
      btn_taken_at[b]   = '0;
    end
    touch_tally = '0;
    online_now  = 1'b1;
  endfunction

  function automatic void apply_reg(logic [dbbc_pkg::CFG_IDX_W-1:0] idx,
                                    logic [dbbc_pkg::CFG_DATA_W-1:0] value);
    case (idx)
      dbbc_pkg::REG_DEBOUNCE:    cf_debounce    = value;
      dbbc_pkg::REG_PRESS_LOCK:  cf_press_lock  = value;
      dbbc_pkg::REG_TOGGLE_LOCK: cf_toggle_lock = value;
      dbbc_pkg::REG_BPM_BASE:    cf_base        = value[dbbc_pkg::BASE_W-1:0];
      dbbc_pkg::REG_BPM_STEP:    cf_step        = value[dbbc_pkg::STEP_W-1:0];
      dbbc_pkg::REG_BPM_MAX:     cf_max         = value[dbbc_pkg::MAX_W-1:0];
      default: ;
    endcase
  endfunction

  // wrapping time since the last accepted press; records the time when clear
  function automatic bit lockout_clear(int b, logic [dbbc_pkg::TS_W-1:0] now,
                                       logic [dbbc_pkg::DEB_W-1:0] span);
    logic [dbbc_pkg::TS_W-1:0] since;
    since = now - btn_taken_at[b];
    if (since < 32'(span)) return 1'b0;
    btn_taken_at[b] = now;
    return 1'b1;
  endfunction

  function automatic void run_handler(int b, logic [dbbc_pkg::TS_W-1:0] now);
    logic [31:0] next_bpm;
    if (b == dbbc_pkg::BTN_UP) begin
      if (lockout_clear(b, now, cf_press_lock)) begin
        next_bpm = 32'(cf_base) + 32'(cf_step) * (32'(touch_tally) + 32'd1);
        if (next_bpm <= 32'(cf_max) && touch_tally != dbbc_pkg::COUNT_MAX) touch_tally++;
      end
    end else if (b == dbbc_pkg::BTN_DOWN) begin
      if (lockout_clear(b, now, cf_press_lock) && touch_tally != '0) touch_tally--;
    end else begin
      if (lockout_clear(b, now, cf_toggle_lock)) online_now = ~online_now;
    end
  endfunction

  function automatic void debounce_button(int b, logic lvl, logic [dbbc_pkg::TS_W-1:0] now);
    logic [dbbc_pkg::TS_W-1:0] held;
    if (lvl != btn_seen[b]) begin
      btn_changed_at[b] = now;
      btn_seen[b]       = lvl;
    end
    held = now - btn_changed_at[b];
    if (held > 32'(cf_debounce) && lvl != btn_stable[b]) begin
      btn_stable[b] = lvl;
      if (!lvl) run_handler(b, now);
    end
  endfunction

  function automatic bpm_reading_t predict_reading(poll_word_t w);
    bpm_reading_t r;
    logic [31:0]  bpm;
    debounce_button(dbbc_pkg::BTN_UP, w.up_level, w.now_ms);
    debounce_button(dbbc_pkg::BTN_DOWN, w.down_level, w.now_ms);
    debounce_button(dbbc_pkg::BTN_TOGGLE, w.toggle_level, w.now_ms);
    bpm = 32'(cf_base) + 32'(cf_step) * 32'(touch_tally);
    if (bpm > 32'(dbbc_pkg::BPM_OUT_MAX)) bpm = 32'(dbbc_pkg::BPM_OUT_MAX);
    r.bpm_value   = bpm[dbbc_pkg::BPM_W-1:0];
    r.touches     = touch_tally;
    r.link_online = online_now;
    return r;
  endfunction

  // poll driver
  always @(posedge clk) begin : poll_driver
    poll_word_t w;
    if (rst) begin
      poll.valid <= 1'b0;
      tx_wait    <= 0;
    end else if (!poll.valid || poll.ready) begin
      if (tx_wait > 0) begin
        poll.valid <= 1'b0;
        tx_wait    <= tx_wait - 1;
      end else if (poll_backlog.size() > 0) begin
        w = poll_backlog.pop_front();
        poll.valid        <= 1'b1;
        poll.now_ms       <= w.now_ms;
        poll.up_level     <= w.up_level;
        poll.down_level   <= w.down_level;
        poll.toggle_level <= w.toggle_level;
        tx_wait           <= draw_wait(tx_calm);
      end else begin
        poll.valid <= 1'b0;
      end
    end
  end

  // result side stalls
  always @(posedge clk) begin : result_stall
    int nxt;
    if (rst) begin
      result.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (result.valid && result.ready) begin
      nxt = draw_wait(rx_calm);
      rx_wait      <= nxt;
      result.ready <= (nxt == 0);
    end else if (rx_wait > 0) begin
      rx_wait      <= rx_wait - 1;
      result.ready <= (rx_wait == 1);
    end else begin
      result.ready <= 1'b1;
    end
  end

  // monitor: track register writes, predict per accepted poll, check results
  always @(posedge clk) begin : reading_check
    bpm_reading_t want, got;
    if (rst) begin
      wipe_counter_state();
    end else begin
      if (cfg.valid && cfg.ready) apply_reg(cfg.index, cfg.data);
      if (result.valid && result.ready) begin
        got = '{result.bpm_value, result.touches, result.link_online};
        if (readings_due.size() == 0) begin
          $display("%0t: result word with none expected: bpm %0d touches %0d online %0d",
                   $time, got.bpm_value, got.touches, got.link_online);
          fails++;
        end else begin
          want = readings_due.pop_front();
          if (got.bpm_value != want.bpm_value) begin
            $display("%0t: bpm_value expected %0d actual %0d",
                     $time, want.bpm_value, got.bpm_value);
            fails++;
          end
          if (got.touches != want.touches) begin
            $display("%0t: touches expected %0d actual %0d", $time, want.touches, got.touches);
            fails++;
          end
          if (got.link_online != want.link_online) begin
            $display("%0t: link_online expected %0d actual %0d",
                     $time, want.link_online, got.link_online);
            fails++;
          end
        end
      end
      if (poll.valid && poll.ready)
        readings_due.push_back(predict_reading('{poll.now_ms, poll.up_level,
                                                 poll.down_level, poll.toggle_level}));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((poll.valid && poll.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_poll(logic [dbbc_pkg::TS_W-1:0] now, logic up, logic down, logic tog);
    poll_backlog.push_back('{now, up, down, tog});
    clock_ms = now;
  endtask

  // press/release sequences with random holds, bounce and noise
  task automatic add_presses(int n, int up_pct, int down_pct, int span);
    logic lvl[dbbc_pkg::NUM_BUTTONS];
    int   pct;
    bit   noise;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) clock_ms += $urandom();
      else clock_ms += $urandom_range(0, span);
      noise = ($urandom_range(0, 9) == 0);
      for (int b = 0; b < dbbc_pkg::NUM_BUTTONS; b++) begin
        if (hold_left[b] == 0) begin
          pct = (b == dbbc_pkg::BTN_UP) ? up_pct :
                (b == dbbc_pkg::BTN_DOWN) ? down_pct : 20;
          press_hold[b] = ($urandom_range(0, 99) < pct);
          hold_left[b]  = $urandom_range(1, 6);
        end else begin
          hold_left[b]--;
        end
        if (noise) lvl[b] = 1'($urandom_range(0, 1));
        else lvl[b] = !press_hold[b] ^ ($urandom_range(0, 11) == 0);
      end
      add_poll(clock_ms, lvl[dbbc_pkg::BTN_UP], lvl[dbbc_pkg::BTN_DOWN],
               lvl[dbbc_pkg::BTN_TOGGLE]);
    end
  endtask

  task automatic write_reg(logic [dbbc_pkg::CFG_IDX_W-1:0] idx,
                           logic [dbbc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic set_regs(logic [dbbc_pkg::DEB_W-1:0] deb, logic [dbbc_pkg::DEB_W-1:0] plock,
                          logic [dbbc_pkg::DEB_W-1:0] tlock,
                          logic [dbbc_pkg::BASE_W-1:0] base,
                          logic [dbbc_pkg::STEP_W-1:0] step,
                          logic [dbbc_pkg::MAX_W-1:0] top);
    write_reg(dbbc_pkg::REG_DEBOUNCE, deb);
    write_reg(dbbc_pkg::REG_PRESS_LOCK, plock);
    write_reg(dbbc_pkg::REG_TOGGLE_LOCK, tlock);
    write_reg(dbbc_pkg::REG_BPM_BASE, {8'($urandom), base});
    write_reg(dbbc_pkg::REG_BPM_STEP, {10'($urandom), step});
    write_reg(dbbc_pkg::REG_BPM_MAX, {6'($urandom), top});
  endtask

  // wait until every poll has gone in and every result has come back
  task automatic settle();
    do @(negedge clk);
    while (poll_backlog.size() != 0 || poll.valid || readings_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst               = 1'b1;
    fails             = 0;
    idle_cycles       = 0;
    tx_calm           = 0;
    rx_calm           = 0;
    poll.valid        = 1'b0;
    poll.now_ms       = '0;
    poll.up_level     = 1'b1;
    poll.down_level   = 1'b1;
    poll.toggle_level = 1'b1;
    result.ready      = 1'b0;
    cfg.valid         = 1'b0;
    cfg.index         = dbbc_pkg::REG_DEBOUNCE;
    cfg.data          = '0;
    clock_ms          = '0;
    for (int b = 0; b < dbbc_pkg::NUM_BUTTONS; b++) begin
      press_hold[b] = 1'b0;
      hold_left[b]  = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed, reset register values
    // press right after reset falls inside the lockout from time zero
    add_poll(32'd5, 1'b0, 1'b1, 1'b1);
    add_poll(32'd30, 1'b0, 1'b1, 1'b1);
    add_poll(32'd40, 1'b1, 1'b1, 1'b1);
    add_poll(32'd70, 1'b1, 1'b1, 1'b1);
    // held exactly the debounce time does not count, one more ms does
    add_poll(32'd200, 1'b0, 1'b1, 1'b1);
    add_poll(32'd220, 1'b0, 1'b1, 1'b1);
    add_poll(32'd221, 1'b0, 1'b1, 1'b1);
    // bounce restarts the timer
    add_poll(32'd230, 1'b1, 1'b1, 1'b1);
    add_poll(32'd240, 1'b0, 1'b1, 1'b1);
    add_poll(32'd251, 1'b0, 1'b1, 1'b1);
    add_poll(32'd300, 1'b1, 1'b1, 1'b1);
    add_poll(32'd330, 1'b1, 1'b1, 1'b1);
    // down press takes the count back to zero, then a toggle press
    add_poll(32'd400, 1'b1, 1'b0, 1'b1);
    add_poll(32'd430, 1'b1, 1'b0, 1'b1);
    add_poll(32'd440, 1'b1, 1'b1, 1'b1);
    add_poll(32'd460, 1'b1, 1'b1, 1'b0);
    add_poll(32'd500, 1'b1, 1'b1, 1'b0);
    // up and down in one poll cancel, toggle already held low
    add_poll(32'd600, 1'b0, 1'b0, 1'b0);
    add_poll(32'd700, 1'b0, 1'b0, 1'b0);
    add_poll(32'd800, 1'b1, 1'b1, 1'b1);
    add_poll(32'd900, 1'b1, 1'b1, 1'b1);
    // timestamp wrap across the debounce window
    add_poll(32'hFFFF_FFF0, 1'b0, 1'b1, 1'b1);
    add_poll(32'h0000_0010, 1'b0, 1'b1, 1'b1);
    add_poll(32'h0000_0040, 1'b1, 1'b1, 1'b1);
    settle();

    // fast counting, no lockouts; spare indexes must be ignored
    set_regs(16'd3, 16'd0, 16'd0, 8'd0, 6'd1, 10'd1023);
    write_reg(REG_SPARE_LO, 16'($urandom));
    write_reg(REG_SPARE_HI, 16'($urandom));
    add_presses(150, 60, 8, 4);
    settle();

    // large step after counting drives the bpm output into saturation
    set_regs(16'd3, 16'd0, 16'd0, 8'd255, 6'd63, 10'd1023);
    add_presses(60, 30, 45, 4);
    settle();

    // zero debounce, zero step and zero ceiling
    set_regs(16'd0, 16'd0, 16'd0, 8'($urandom_range(0, 1) * $urandom_range(0, 255)),
             6'd0, 10'd0);
    add_presses(60, 50, 30, 3);
    settle();

    // largest timers, slow timeline
    set_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 6'd63, 10'd0);
    add_presses(60, 40, 40, 30000);
    settle();

    // random settings; the first one pauses midway until all results are back
    for (int ph = 0; ph < 5; ph++) begin
      set_regs(16'($urandom_range(0, 50)), 16'($urandom_range(0, 300)),
               16'($urandom_range(0, 500)), 8'($urandom), 6'($urandom_range(0, 63)),
               10'($urandom));
      add_presses(30, $urandom_range(20, 70), $urandom_range(10, 50), 40);
      if (ph == 0) settle();
      add_presses(30, $urandom_range(20, 70), $urandom_range(10, 50), 40);
      settle();
    end

    repeat (8) @(posedge clk);
    if (fails == 0 && readings_due.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
sv/dbbc_pkg.sv
sv/dbbc_if.sv
sv/dbbc_debounce.sv
sv/debounced_button_bpm_counter_core.sv
sim/tb.sv
